// ===== design/mfer_pkg.sv =====
package mfer_pkg;

    // Table geometry
    localparam int NUM_SPECIES = 64;
    localparam int SPEC_W      = 6;
    localparam int ADDR_W      = $clog2(NUM_SPECIES);

    // Field widths
    localparam int COEF_W  = 24;
    localparam int SUM_W   = 48;
    localparam int Z_W     = 16;
    localparam int RATIO_W = 24;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_BETA_OX = 2'd0;
    localparam logic [1:0] REG_BETA_FU = 2'd1;
    localparam logic [1:0] REG_AFR_ST  = 2'd2;

    localparam logic signed [COEF_W-1:0] BETA_OX_RST = -24'sd15268;
    localparam logic signed [COEF_W-1:0] BETA_FU_RST = 24'sd262144;
    localparam logic [RATIO_W-1:0]       AFR_ST_RST  = 24'd1125253;

    // Item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_ACC  = 1'b1;

    // Fixed-point constants
    localparam logic [Z_W-1:0]     Z_ONE      = 16'd32768;
    localparam logic [Z_W-1:0]     Z_ONE_LSB  = 16'd32769;
    localparam logic [RATIO_W-1:0] RATIO_MAX  = 24'hFFFFFF;

    // Shared divider: remainder width and quotient bit counts less one
    localparam int DIV_W   = 24;
    localparam int CNT_W   = 5;
    localparam logic [CNT_W-1:0] Z_STEPS_M1 = 5'd15;
    localparam logic [CNT_W-1:0] R_STEPS_M1 = 5'd23;

    typedef struct packed {
        logic mem_wr;     // write coefficient table
        logic capture;    // latch mass fraction, read table
        logic mul;        // register coefficient * mass fraction
        logic acc;        // add product into coupling sum
        logic znum;       // form numerator and denominator
        logic zmag;       // take magnitudes and the zero test
        logic zload;      // overflow test, load divider for Z
        logic div_step;   // one restoring division step
        logic zfin;       // clamp and register Z
        logic rprod;      // Z * air-fuel ratio and 1 - Z + 1 LSB
        logic rload;      // overflow test, load divider for the ratio
        logic out_load;   // load result register, clear coupling sum
    } mfer_cmd_t;

endpackage

// ===== design/mfer_if.sv =====
interface mfer_item_if
    import mfer_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [SPEC_W-1:0]        species_index;
    logic signed [COEF_W-1:0] value;
    logic                     last;

    modport source (output valid, mode, species_index, value, last, input ready);
    modport sink   (input valid, mode, species_index, value, last, output ready);
endinterface

interface mfer_result_if
    import mfer_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [Z_W-1:0]     mixture_fraction;
    logic [RATIO_W-1:0] equivalence_ratio;
    logic               saturated;

    modport source (output valid, mixture_fraction, equivalence_ratio, saturated,
                    input ready);
    modport sink   (input valid, mixture_fraction, equivalence_ratio, saturated,
                    output ready);
endinterface

// ===== design/mfer_regs.sv =====
module mfer_regs
    import mfer_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,
    output logic signed [COEF_W-1:0]   beta_ox,
    output logic signed [COEF_W-1:0]   beta_fu,
    output logic [RATIO_W-1:0]         afr_st
);

    logic signed [COEF_W-1:0] beta_ox_reg, beta_ox_next;
    logic signed [COEF_W-1:0] beta_fu_reg, beta_fu_next;
    logic [RATIO_W-1:0]       afr_st_reg, afr_st_next;
    logic                     wr_en;
    logic [1:0]               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_comb
    begin
        beta_ox_next = beta_ox_reg;
        beta_fu_next = beta_fu_reg;
        afr_st_next  = afr_st_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_BETA_OX: beta_ox_next = pwdata[COEF_W-1:0];
                REG_BETA_FU: beta_fu_next = pwdata[COEF_W-1:0];
                REG_AFR_ST:  afr_st_next  = pwdata[RATIO_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_BETA_OX: prdata = {{(PDATA_W-COEF_W){beta_ox_reg[COEF_W-1]}}, beta_ox_reg};
            REG_BETA_FU: prdata = {{(PDATA_W-COEF_W){beta_fu_reg[COEF_W-1]}}, beta_fu_reg};
            REG_AFR_ST:  prdata = {{(PDATA_W-RATIO_W){1'b0}}, afr_st_reg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_ox_reg <= BETA_OX_RST;
            beta_fu_reg <= BETA_FU_RST;
            afr_st_reg  <= AFR_ST_RST;
        end
        else
        begin
            beta_ox_reg <= beta_ox_next;
            beta_fu_reg <= beta_fu_next;
            afr_st_reg  <= afr_st_next;
        end
    end

    assign beta_ox = beta_ox_reg;
    assign beta_fu = beta_fu_reg;
    assign afr_st  = afr_st_reg;

endmodule

// ===== design/mfer_ctrl.sv =====
module mfer_ctrl
    import mfer_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      item_mode,
    input  logic      item_last,
    output logic      item_ready,
    input  logic      res_ready,
    output logic      res_valid,
    output mfer_cmd_t cmd
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_MUL   = 12'b0000_0000_0010,
        S_ACC   = 12'b0000_0000_0100,
        S_ZNUM  = 12'b0000_0000_1000,
        S_ZMAG  = 12'b0000_0001_0000,
        S_ZLOAD = 12'b0000_0010_0000,
        S_ZDIV  = 12'b0000_0100_0000,
        S_ZFIN  = 12'b0000_1000_0000,
        S_RPROD = 12'b0001_0000_0000,
        S_RLOAD = 12'b0010_0000_0000,
        S_RDIV  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } mfer_state_t;

    mfer_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              last_reg, last_next;
    logic              acc_pend_reg, acc_pend_next;
    logic              res_valid_reg, res_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        acc_pend_next  = acc_pend_reg;
        res_valid_next = res_valid_reg && !res_ready;
        item_ready     = 1'b0;
        cmd            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready    = 1'b1;
                // finish the previous species' accumulation in passing
                cmd.acc       = acc_pend_reg;
                acc_pend_next = 1'b0;
                if (item_valid)
                begin
                    if (item_mode == MODE_LOAD)
                    begin
                        cmd.mem_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        last_next   = item_last;
                        state_next  = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                if (last_reg)
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    acc_pend_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_ZNUM;
            end
            S_ZNUM:
            begin
                cmd.znum   = 1'b1;
                state_next = S_ZMAG;
            end
            S_ZMAG:
            begin
                cmd.zmag   = 1'b1;
                state_next = S_ZLOAD;
            end
            S_ZLOAD:
            begin
                cmd.zload  = 1'b1;
                cnt_next   = Z_STEPS_M1;
                state_next = S_ZDIV;
            end
            S_ZDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_ZFIN;
                end
            end
            S_ZFIN:
            begin
                cmd.zfin   = 1'b1;
                state_next = S_RPROD;
            end
            S_RPROD:
            begin
                cmd.rprod  = 1'b1;
                state_next = S_RLOAD;
            end
            S_RLOAD:
            begin
                cmd.rload  = 1'b1;
                cnt_next   = R_STEPS_M1;
                state_next = S_RDIV;
            end
            S_RDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (!res_valid_reg || res_ready)
                begin
                    cmd.out_load   = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            acc_pend_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            acc_pend_reg  <= acc_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

// ===== design/mfer_dp.sv =====
module mfer_dp
    import mfer_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mfer_cmd_t                cmd,
    input  logic [SPEC_W-1:0]        species_index,
    input  logic signed [COEF_W-1:0] value,
    input  logic signed [COEF_W-1:0] beta_ox,
    input  logic signed [COEF_W-1:0] beta_fu,
    input  logic [RATIO_W-1:0]       afr_st,
    output logic [Z_W-1:0]           mixture_fraction,
    output logic [RATIO_W-1:0]       equivalence_ratio,
    output logic                     saturated
);

    // Coefficient table
    logic signed [COEF_W-1:0] coef_mem [NUM_SPECIES];
    logic signed [COEF_W-1:0] coef_q_reg;
    logic [ADDR_W-1:0]        addr;
    logic                     idx_ok;

    // Multiply-accumulate
    logic signed [COEF_W-1:0] val_reg;
    logic                     val_ok_reg;
    logic signed [SUM_W-1:0]  prod_reg;
    logic                     prod_ok_reg;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [SUM_W:0]           sum_ext;

    // Mixture fraction
    logic [SUM_W:0]           num_reg;
    logic [COEF_W:0]          den_reg;
    logic [SUM_W-1:0]         nmag_reg;
    logic [DIV_W-1:0]         dmag_reg;
    logic                     zzero_reg;
    logic                     zovf_reg;
    logic [Z_W-1:0]           z_reg;
    logic [Z_W-1:0]           zq;

    // Equivalence ratio
    logic [Z_W+RATIO_W-1:0]   rp_reg;
    logic [Z_W-1:0]           rd_reg;
    logic                     rovf_reg;

    // Shared restoring divider
    logic [DIV_W-1:0]         rem_reg;
    logic [DIV_W-1:0]         low_reg;
    logic [DIV_W-1:0]         dvs_reg;
    logic [DIV_W:0]           trial;
    logic [DIV_W:0]           trial_sub;
    logic                     q_bit;

    // Result register
    logic [Z_W-1:0]           mf_reg;
    logic [RATIO_W-1:0]       er_reg;
    logic                     sat_reg;

    assign addr   = ADDR_W'(species_index);
    assign idx_ok = (int'(species_index) < NUM_SPECIES);

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr && idx_ok)
        begin
            coef_mem[addr] <= value;
        end
        if (cmd.capture)
        begin
            coef_q_reg <= coef_mem[addr];
        end
    end

    // Saturating accumulate; cleared when the result register loads
    always_comb
    begin
        sum_ext  = {sum_reg[SUM_W-1], sum_reg} + {prod_reg[SUM_W-1], prod_reg};
        sum_next = sum_reg;
        if (cmd.out_load)
        begin
            sum_next = '0;
        end
        else if (cmd.acc && prod_ok_reg)
        begin
            if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
            begin
                sum_next = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                          : {1'b0, {(SUM_W-1){1'b1}}};
            end
            else
            begin
                sum_next = sum_ext[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    // Division step: shift one dividend bit in, subtract where it fits
    assign trial     = {rem_reg, low_reg[DIV_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign q_bit     = (trial >= {1'b0, dvs_reg});
    assign zq        = low_reg[Z_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            val_reg    <= value;
            val_ok_reg <= idx_ok;
        end
        if (cmd.mul)
        begin
            prod_reg    <= coef_q_reg * val_reg;
            prod_ok_reg <= val_ok_reg;
        end
        if (cmd.znum)
        begin
            num_reg <= {sum_reg[SUM_W-1], sum_reg}
                     - {{(SUM_W-COEF_W-14){beta_ox[COEF_W-1]}}, beta_ox, 15'd0};
            den_reg <= {beta_fu[COEF_W-1], beta_fu} - {beta_ox[COEF_W-1], beta_ox};
        end
        if (cmd.zmag)
        begin
            nmag_reg  <= num_reg[SUM_W] ? SUM_W'(~num_reg + 1'b1) : num_reg[SUM_W-1:0];
            dmag_reg  <= den_reg[COEF_W] ? DIV_W'(~den_reg + 1'b1) : den_reg[DIV_W-1:0];
            zzero_reg <= (den_reg == '0) || (num_reg == '0)
                      || (num_reg[SUM_W] != den_reg[COEF_W]);
        end
        if (cmd.zload)
        begin
            zovf_reg <= (nmag_reg >= {{(SUM_W-DIV_W-Z_W){1'b0}}, dmag_reg, {Z_W{1'b0}}});
            rem_reg  <= nmag_reg[DIV_W+Z_W-1:Z_W];
            low_reg  <= {nmag_reg[Z_W-1:0], {(DIV_W-Z_W){1'b0}}};
            dvs_reg  <= dmag_reg;
        end
        else if (cmd.rload)
        begin
            rovf_reg <= (rp_reg >= {rd_reg, {RATIO_W{1'b0}}});
            rem_reg  <= {{(DIV_W-Z_W){1'b0}}, rp_reg[Z_W+RATIO_W-1:RATIO_W]};
            low_reg  <= rp_reg[RATIO_W-1:0];
            dvs_reg  <= {{(DIV_W-Z_W){1'b0}}, rd_reg};
        end
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
            low_reg <= {low_reg[DIV_W-2:0], q_bit};
        end
        if (cmd.zfin)
        begin
            if (zzero_reg)
            begin
                z_reg <= '0;
            end
            else if (zovf_reg || (zq > Z_ONE))
            begin
                z_reg <= Z_ONE;
            end
            else
            begin
                z_reg <= zq;
            end
        end
        if (cmd.rprod)
        begin
            rp_reg <= z_reg * afr_st;
            rd_reg <= Z_ONE_LSB - z_reg;
        end
        if (cmd.out_load)
        begin
            mf_reg  <= z_reg;
            er_reg  <= rovf_reg ? RATIO_MAX : low_reg;
            sat_reg <= rovf_reg;
        end
    end

    assign mixture_fraction  = mf_reg;
    assign equivalence_ratio = er_reg;
    assign saturated         = sat_reg;

endmodule

// ===== design/mixture_fraction_equivalence_ratio.sv =====
// Mixture fraction and equivalence ratio. Requests arrive on the item channel:
// mode 0 writes one species coefficient (signed Q3.20) into a 64-entry table,
// mode 1 multiplies a species mass fraction (Q1.15) by that species'
// coefficient and adds it to a saturating 48-bit coupling sum. A mode-1 request
// marked last closes the cell; one result then leaves on the result channel:
// Z = (sum - beta_oxidizer) / (beta_fuel - beta_oxidizer) clamped to [0,1] in
// Q1.15 (0 when the betas are equal), the equivalence ratio
// Z / (1 - Z + 1 LSB) * air_fuel_ratio_st in Q8.16, and a flag set when that
// ratio clipped at its maximum. Mode-0 requests are written in the idle state;
// a mode-1 request stalls the next for a registered table read and the 24 x 24
// multiply, its add folded into the next idle cycle (its own add step if last).
// Closing a cell runs the shared restoring divider: 16 steps for Z and 24 for
// the ratio, one quotient bit per cycle, plus set-up and clamp stages. The
// result sits in an output register, so the next cell's requests are taken
// while it waits; a second finished cell holds until the first is taken.
// Registers on the APB port: beta_oxidizer at 0x0, beta_fuel at 0x4,
// air_fuel_ratio_st at 0x8; write them only while the block is idle.
module mixture_fraction_equivalence_ratio
    import mfer_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    mfer_item_if.sink           item,
    mfer_result_if.source       result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    mfer_cmd_t                cmd;
    logic signed [COEF_W-1:0] beta_ox;
    logic signed [COEF_W-1:0] beta_fu;
    logic [RATIO_W-1:0]       afr_st;

    // Configuration registers behind the APB port
    mfer_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .beta_ox (beta_ox),
        .beta_fu (beta_fu),
        .afr_st  (afr_st)
    );

    // Sequencer: accepts requests, steps the datapath, owns result valid
    mfer_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_mode  (item.mode),
        .item_last  (item.last),
        .item_ready (item.ready),
        .res_ready  (result.ready),
        .res_valid  (result.valid),
        .cmd        (cmd)
    );

    // Table, multiply-accumulate, divider and result register
    mfer_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .species_index     (item.species_index),
        .value             (item.value),
        .beta_ox           (beta_ox),
        .beta_fu           (beta_fu),
        .afr_st            (afr_st),
        .mixture_fraction  (result.mixture_fraction),
        .equivalence_ratio (result.equivalence_ratio),
        .saturated         (result.saturated)
    );

endmodule

// ===== design/mfer_checker.sv =====
module mfer_checker
    import mfer_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic [Z_W-1:0]     mixture_fraction,
    input logic [RATIO_W-1:0] equivalence_ratio,
    input logic               saturated
);

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(mixture_fraction)
            && $stable(equivalence_ratio) && $stable(saturated))
        else $error("stalled result changed");

    a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> mixture_fraction <= Z_ONE)
        else $error("mixture fraction above one");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && saturated |-> equivalence_ratio == RATIO_MAX)
        else $error("saturated ratio not at maximum");

    a_z_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && mixture_fraction == '0 |-> equivalence_ratio == '0 && !saturated)
        else $error("zero mixture fraction with non-zero ratio");

endmodule

bind mixture_fraction_equivalence_ratio mfer_checker u_mfer_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (result.valid),
    .res_ready         (result.ready),
    .mixture_fraction  (result.mixture_fraction),
    .equivalence_ratio (result.equivalence_ratio),
    .saturated         (result.saturated)
);

// ===== sim/tb_top.sv =====
module tb_top
    import mfer_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Run limits: the slowest legal run is roughly 1300 requests, each closing a cell
    // behind the longest stall on both sides; the limit is several times that.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 100;

    // Coupling sum limits, 48-bit signed
    localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    typedef struct packed {
        logic               mode;
        logic [SPEC_W-1:0]  species_index;
        logic [COEF_W-1:0]  value;
        logic               last;
    } species_req_t;

    typedef struct packed {
        logic [Z_W-1:0]     mixture_fraction;
        logic [RATIO_W-1:0] equivalence_ratio;
        logic               saturated;
    } cell_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    mfer_item_if   req_bus ();
    mfer_result_if res_bus ();

    mixture_fraction_equivalence_ratio u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (req_bus),
        .result  (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mirror of the block's state: coefficient table, coupling sum and the
    // three registers as last written
    logic signed [COEF_W-1:0] coef_tbl [NUM_SPECIES];
    longint                   coupling_sum = 0;
    logic signed [COEF_W-1:0] beta_ox_cfg  = BETA_OX_RST;
    logic signed [COEF_W-1:0] beta_fu_cfg  = BETA_FU_RST;
    logic [RATIO_W-1:0]       afr_cfg      = AFR_ST_RST;

    // Requests waiting to go out, and results owed by closed cells
    species_req_t species_req_q [$];
    cell_result_t cell_results_q [$];

    // Table entries that have been loaded, so a cell never reads an unwritten one
    bit loaded [NUM_SPECIES];
    int loaded_list [$];

    int           errors      = 0;
    int           cycle_count = 0;
    int           idle_pct    = 0;
    int           src_gap     = 0;
    int           snk_gap     = 0;
    bit           hold_items  = 1'b0;
    bit           req_fire    = 1'b0;
    cell_result_t want;

    always #6ns clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Advance the mirrored state by one accepted request; a mode-1 request
    // marked last closes the cell and owes one result.
    task automatic advance_mixture(input species_req_t r);
        longint       sum;
        longint       num;
        longint       den;
        longint       z;
        longint       ratio;
        cell_result_t res;
        if (r.mode == MODE_LOAD)
        begin
            // last means nothing on a load
            coef_tbl[r.species_index] = $signed(r.value);
            return;
        end
        // Product is exact in Q.35; the sum clips at the 48-bit range
        sum = coupling_sum
            + longint'(coef_tbl[r.species_index]) * longint'($signed(r.value));
        if (sum > SUM_MAX)
            sum = SUM_MAX;
        if (sum < SUM_MIN)
            sum = SUM_MIN;
        coupling_sum = sum;
        if (!r.last)
            return;

        // Z = (sum - beta_ox) / (beta_fu - beta_ox), Q1.15, truncated, clamped;
        // equal betas, a zero numerator or opposite signs give zero
        den = longint'(beta_fu_cfg) - longint'(beta_ox_cfg);
        num = coupling_sum - longint'(beta_ox_cfg) * 32768;
        if (den == 0 || num == 0 || ((num < 0) != (den < 0)))
            z = 0;
        else
        begin
            z = (num < 0 ? -num : num) / (den < 0 ? -den : den);
            if (z > longint'(Z_ONE))
                z = longint'(Z_ONE);
        end
        coupling_sum = 0;

        // Ratio Z / (1 - Z + 1 LSB) scaled by the air-fuel ratio; clip and flag
        ratio = (z * longint'(afr_cfg)) / (longint'(Z_ONE_LSB) - z);
        res.saturated = (ratio > longint'(RATIO_MAX));
        if (res.saturated)
            ratio = longint'(RATIO_MAX);
        res.mixture_fraction  = z[Z_W-1:0];
        res.equivalence_ratio = ratio[RATIO_W-1:0];
        cell_results_q.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Request driver: changes at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        // Drop the request taken at the last rising edge
        if (req_fire)
            void'(species_req_q.pop_front());
        if (!rst_n)
            req_bus.valid <= 1'b0;
        else if (req_bus.valid && !req_fire)
        begin
            // hold the offered request until it is taken
        end
        else if (src_gap != 0)
        begin
            src_gap = src_gap - 1;
            req_bus.valid <= 1'b0;
        end
        else if ($urandom_range(0, 99) < idle_pct)
        begin
            // open an idle burst
            src_gap = $urandom_range(1, 19) - 1;
            req_bus.valid <= 1'b0;
        end
        else if (species_req_q.size() != 0 && !hold_items)
        begin
            req_bus.valid         <= 1'b1;
            req_bus.mode          <= species_req_q[0].mode;
            req_bus.species_index <= species_req_q[0].species_index;
            req_bus.value         <= species_req_q[0].value;
            req_bus.last          <= species_req_q[0].last;
        end
        else
            req_bus.valid <= 1'b0;
    end

    // Result sink: stalls in bursts as well
    always @(negedge clk)
    begin
        if (snk_gap != 0)
        begin
            snk_gap = snk_gap - 1;
            res_bus.ready <= 1'b0;
        end
        else if (rst_n && $urandom_range(0, 99) < idle_pct)
        begin
            snk_gap = $urandom_range(1, 19) - 1;
            res_bus.ready <= 1'b0;
        end
        else
            res_bus.ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        req_fire <= rst_n && req_bus.valid && req_bus.ready;

        // Results come before the prediction of this edge's request: a result
        // can never belong to a request taken at the same edge
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (cell_results_q.size() == 0)
            begin
                $error("result with no closed cell: mixture_fraction %0d, ratio %0d",
                       res_bus.mixture_fraction, res_bus.equivalence_ratio);
                errors = errors + 1;
            end
            else
            begin
                want = cell_results_q.pop_front();
                if (res_bus.mixture_fraction !== want.mixture_fraction)
                begin
                    $error("mixture_fraction: expected %0d, got %0d",
                           want.mixture_fraction, res_bus.mixture_fraction);
                    errors = errors + 1;
                end
                if (res_bus.equivalence_ratio !== want.equivalence_ratio)
                begin
                    $error("equivalence_ratio: expected %0d, got %0d",
                           want.equivalence_ratio, res_bus.equivalence_ratio);
                    errors = errors + 1;
                end
                if (res_bus.saturated !== want.saturated)
                begin
                    $error("saturated: expected %0d, got %0d",
                           want.saturated, res_bus.saturated);
                    errors = errors + 1;
                end
            end
        end

        if (rst_n && req_bus.valid && req_bus.ready)
            advance_mixture({req_bus.mode, req_bus.species_index,
                             req_bus.value, req_bus.last});
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------

    // Write one register (setup then access), update the mirror at the write
    // edge, then read it back.
    task automatic write_register(input logic [1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {8'h00, val};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_BETA_OX: beta_ox_cfg = val;
            REG_BETA_FU: beta_fu_cfg = val;
            REG_AFR_ST:  afr_cfg     = val;
            default: ;
        endcase

        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[COEF_W-1:0] !== val)
        begin
            $error("register %0d read back: expected %0h, got %0h",
                   idx, val, prdata[COEF_W-1:0]);
            errors = errors + 1;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apply_setting(input int beta_ox, input int beta_fu, input int afr);
        write_register(REG_BETA_OX, beta_ox[COEF_W-1:0]);
        write_register(REG_BETA_FU, beta_fu[COEF_W-1:0]);
        write_register(REG_AFR_ST, afr[RATIO_W-1:0]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_request(input logic md, input int idx, input int val,
                                 input logic lst);
        species_req_t r;
        r.mode          = md;
        r.species_index = idx[SPEC_W-1:0];
        r.value         = val[COEF_W-1:0];
        r.last          = lst;
        species_req_q.push_back(r);
        if (md == MODE_LOAD && !loaded[r.species_index])
        begin
            loaded[r.species_index] = 1'b1;
            loaded_list.push_back(int'(r.species_index));
        end
    endtask

    function automatic int any_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    // Mostly within +/-1.0 so that Z lands inside (0,1); otherwise anything
    function automatic int random_coef();
        if ($urandom_range(0, 3) != 0)
            return int'($urandom_range(0, 2097152)) - 1048576;
        return int'($urandom);
    endfunction

    // Fractions of at most one over the cell size, with the odd zero or full one
    function automatic int mass_fraction(input int n_species);
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return int'(Z_ONE);
        if (pick == 1)
            return 0;
        return int'($urandom_range(0, 32768 / n_species));
    endfunction

    task automatic queue_cell(input int n_species);
        for (int i = 0; i < n_species; i++)
            queue_request(MODE_ACC, any_loaded(), mass_fraction(n_species),
                          i == n_species - 1);
    endtask

    // Mostly well-formed cells; some loads between cells (last set at random),
    // and the odd stray mode-1 request with a raw value that may or may not
    // close a cell.
    task automatic queue_random_phase(input int n_items);
        int n_left;
        int n;
        n_left = n_items;
        while (n_left > 0)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    n = $urandom_range(1, 4);
                    repeat (n)
                        queue_request(MODE_LOAD, $urandom_range(0, NUM_SPECIES - 1),
                                      random_coef(), $urandom_range(0, 1));
                end
                9:
                begin
                    n = 1;
                    queue_request(MODE_ACC, any_loaded(), int'($urandom),
                                  $urandom_range(0, 1));
                end
                default:
                begin
                    n = $urandom_range(1, 8);
                    queue_cell(n);
                end
            endcase
            n_left = n_left - n;
        end
    endtask

    task automatic apply_random_setting();
        int beta_ox;
        int beta_fu;
        int afr;
        case ($urandom_range(0, 7))
            0:
            begin
                beta_ox = int'($urandom);
                beta_fu = int'($urandom);
            end
            1:
            begin
                beta_ox = random_coef();
                beta_fu = beta_ox;
            end
            default:
            begin
                beta_ox = int'($urandom_range(0, 262144)) - 131072;
                beta_fu = beta_ox + int'($urandom_range(1, 1048576));
            end
        endcase
        if ($urandom_range(0, 3) == 0)
            afr = int'($urandom);
        else
            afr = int'($urandom_range(65536, 4194304));
        apply_setting(beta_ox, beta_fu, afr);
    endtask

    // Wait until every request is out and every owed result has arrived, then
    // let the block finish any cell still in its pipeline.
    task automatic wait_quiet();
        do @(negedge clk);
        while (species_req_q.size() != 0 || req_bus.valid || cell_results_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        req_bus.valid         = 1'b0;
        req_bus.mode          = MODE_LOAD;
        req_bus.species_index = '0;
        req_bus.value         = '0;
        req_bus.last          = 1'b0;
        res_bus.ready         = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset settings. Load the coefficient extremes and the two
        // betas themselves, plus a load flagged last (ignored).
        idle_pct = 15;
        queue_request(MODE_LOAD, 0, 8388607, 1'b0);
        queue_request(MODE_LOAD, 63, -8388608, 1'b0);
        queue_request(MODE_LOAD, 1, 0, 1'b0);
        queue_request(MODE_LOAD, 2, int'(BETA_FU_RST), 1'b0);
        queue_request(MODE_LOAD, 3, int'(BETA_OX_RST), 1'b0);
        queue_request(MODE_LOAD, 42, 1048576, 1'b1);
        queue_request(MODE_LOAD, 21, -524288, 1'b0);
        // Pure fuel: Z at one, ratio clips
        queue_request(MODE_ACC, 2, 32768, 1'b1);
        // Pure oxidizer: numerator zero
        queue_request(MODE_ACC, 3, 32768, 1'b1);
        // Zero sum: Z strictly inside (0,1)
        queue_request(MODE_ACC, 1, 0, 1'b1);
        // Numerator against the denominator's sign: Z forced to zero
        queue_request(MODE_ACC, 63, 32768, 1'b1);
        // Coupling sum overflows upwards, then downwards
        queue_request(MODE_ACC, 0, 8388607, 1'b0);
        queue_request(MODE_ACC, 0, 8388607, 1'b0);
        queue_request(MODE_ACC, 0, 8388607, 1'b1);
        queue_request(MODE_ACC, 0, -8388608, 1'b0);
        queue_request(MODE_ACC, 0, -8388608, 1'b0);
        queue_request(MODE_ACC, 0, -8388608, 1'b1);
        // Mixed cell
        queue_request(MODE_ACC, 2, 16384, 1'b0);
        queue_request(MODE_ACC, 3, 16384, 1'b0);
        queue_request(MODE_ACC, 42, 100, 1'b1);
        wait_quiet();

        // Equal betas: Z and the ratio are zero whatever the sum
        apply_setting(123456, 123456, 16777215);
        queue_request(MODE_ACC, 2, 20000, 1'b1);
        queue_request(MODE_ACC, 0, 32768, 1'b1);
        wait_quiet();

        // Widest positive span, largest air-fuel ratio
        apply_setting(-8388608, 8388607, 16777215);
        queue_request(MODE_ACC, 0, 32768, 1'b1);
        queue_request(MODE_ACC, 1, 0, 1'b1);
        wait_quiet();

        // Negative span, zero air-fuel ratio
        apply_setting(8388607, -8388608, 0);
        queue_request(MODE_ACC, 63, 32768, 1'b1);
        queue_request(MODE_ACC, 1, 0, 1'b1);
        wait_quiet();

        // Random part, reset settings first. Midway, hold the sender until
        // every owed result is back.
        apply_setting(int'(BETA_OX_RST), int'(BETA_FU_RST), int'(AFR_ST_RST));
        idle_pct = 5;
        queue_random_phase(100);
        do @(negedge clk); while (species_req_q.size() > 10);
        @(posedge clk);
        hold_items = 1'b1;
        do @(negedge clk); while (req_bus.valid || cell_results_q.size() != 0);
        @(posedge clk);
        hold_items = 1'b0;
        queue_random_phase(110);
        wait_quiet();

        // Further settings at random; idling varies, none in the last phase
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: idle_pct = 25;
                1: idle_pct = 3;
                2: idle_pct = 40;
                3: idle_pct = 10;
                default: idle_pct = 0;
            endcase
            apply_random_setting();
            queue_random_phase(210);
            wait_quiet();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mfer_pkg.sv
design/mfer_if.sv
design/mfer_regs.sv
design/mfer_ctrl.sv
design/mfer_dp.sv
design/mixture_fraction_equivalence_ratio.sv
design/mfer_checker.sv
sim/tb_top.sv
